@@ src/dspdc_pkg.sv @@
// shared types and constants for the dual switch press duration classifier
`timescale 1ns / 1ps
`default_nettype none

package dspdc_pkg;

    localparam int unsigned PERIOD_W    = 8;
    localparam int unsigned THRESH_W    = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam int unsigned BIG_STEP_LIMIT = 50;
    localparam int unsigned BIG_STEP       = 50;
    localparam int unsigned MID_STEP_LIMIT = 10;
    localparam int unsigned MID_STEP       = 5;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd10;
    localparam logic [THRESH_W-1:0] FULL_RESET   = 16'd300;
    localparam logic [THRESH_W-1:0] HALF_RESET   = 16'd100;
    localparam logic [THRESH_W-1:0] MIN_RESET    = 16'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SAMPLE_PERIOD  = 2'd0,
        REG_FULL_THRESHOLD = 2'd1,
        REG_HALF_THRESHOLD = 2'd2,
        REG_MIN_THRESHOLD  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        HOLD_NONE = 2'd0,
        HOLD_MIN  = 2'd1,
        HOLD_HALF = 2'd2,
        HOLD_FULL = 2'd3
    } hold_level_t;

    typedef struct packed {
        logic [THRESH_W-1:0] full_threshold;
        logic [THRESH_W-1:0] half_threshold;
        logic [THRESH_W-1:0] min_threshold;
    } thresholds_t;

    typedef struct packed {
        logic first_pressed;
        logic second_pressed;
    } in_item_t;

    typedef struct packed {
        logic [1:0] first_class;
        logic [1:0] second_class;
    } out_item_t;

endpackage

`default_nettype wire

@@ src/dspdc_lane.sv @@
// one switch lane: integrator register, update step and hold classification
`timescale 1ns / 1ps
`default_nettype none

module dspdc_lane #(
    parameter int unsigned INTEGRATOR_WIDTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire logic                  update,
    input  wire logic                  pressed,
    input  wire dspdc_pkg::thresholds_t thresholds,
    output dspdc_pkg::hold_level_t     level
);

    localparam int unsigned W     = INTEGRATOR_WIDTH;
    localparam int unsigned CMP_W = (W > dspdc_pkg::THRESH_W) ? W : dspdc_pkg::THRESH_W;

    localparam logic [W-1:0] BIG_LIMIT = W'(dspdc_pkg::BIG_STEP_LIMIT);
    localparam logic [W-1:0] BIG_DEC   = W'(dspdc_pkg::BIG_STEP);
    localparam logic [W-1:0] MID_LIMIT = W'(dspdc_pkg::MID_STEP_LIMIT);
    localparam logic [W-1:0] MID_DEC   = W'(dspdc_pkg::MID_STEP);

    logic [W-1:0]     integ_reg;
    logic [W-1:0]     integ_next;
    logic [W-1:0]     stepped;
    logic [CMP_W-1:0] value_ext;

    always_comb begin
        if (pressed) begin
            stepped = (integ_reg != {W{1'b1}}) ? integ_reg + W'(1) : integ_reg;
        end else if (integ_reg > BIG_LIMIT) begin
            stepped = integ_reg - BIG_DEC;
        end else if (integ_reg > MID_LIMIT) begin
            stepped = integ_reg - MID_DEC;
        end else if (integ_reg != '0) begin
            stepped = integ_reg - W'(1);
        end else begin
            stepped = '0;
        end
        integ_next = (step && update) ? stepped : integ_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
        end else begin
            integ_reg <= integ_next;
        end
    end

    // classify on the value left after this tick's update
    always_comb begin
        value_ext = CMP_W'(integ_next);
        if (value_ext > CMP_W'(thresholds.full_threshold)) begin
            level = dspdc_pkg::HOLD_FULL;
        end else if (value_ext > CMP_W'(thresholds.half_threshold)) begin
            level = dspdc_pkg::HOLD_HALF;
        end else if (value_ext > CMP_W'(thresholds.min_threshold)) begin
            level = dspdc_pkg::HOLD_MIN;
        end else begin
            level = dspdc_pkg::HOLD_NONE;
        end
    end

endmodule

`default_nettype wire

@@ src/dspdc_merge.sv @@
// merges the lane classes into one result and holds it in a two-entry output queue
`timescale 1ns / 1ps
`default_nettype none

module dspdc_merge (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire dspdc_pkg::hold_level_t first_level,
    input  wire dspdc_pkg::hold_level_t second_level,
    output logic                       full,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output dspdc_pkg::out_item_t       m_data
);

    dspdc_pkg::out_item_t result;
    dspdc_pkg::out_item_t head_reg;
    dspdc_pkg::out_item_t head_next;
    dspdc_pkg::out_item_t tail_reg;
    dspdc_pkg::out_item_t tail_next;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic                 pop;

    always_comb begin
        result.first_class  = first_level;
        result.second_class = second_level;
    end

    assign pop = m_valid && m_ready;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10: begin
                if (count_reg == 2'd0) begin
                    head_next = result;
                end else begin
                    tail_next = result;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01: begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11: begin
                if (count_reg == 2'd1) begin
                    head_next = result;
                end else begin
                    head_next = tail_reg;
                    tail_next = result;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign full    = (count_reg == 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = head_reg;

endmodule

`default_nettype wire

@@ src/dual_switch_press_duration_classifier_unit.sv @@
// top level of the dual switch press duration classifier
// Takes one request per clock while the output queue has room: each request is a timer tick
// carrying both switch levels and returns one result with a hold class per switch, written
// into the output queue. A shared sampling counter counts ticks down; when it reaches zero
// both switch lanes update their integrators in parallel (pressed adds one and saturates,
// released steps down by 50, 5 or 1) and the counter reloads from sample_period. Classes compare
// the updated integrator against the full, half and min thresholds in that order. A two-entry
// output queue lets input requests keep flowing while a result waits; input ready drops only
// when both entries are held. Configuration writes are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none

module dual_switch_press_duration_classifier_unit #(
    parameter int unsigned INTEGRATOR_WIDTH = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire dspdc_pkg::in_item_t                 s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output dspdc_pkg::out_item_t                     m_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [dspdc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [dspdc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [dspdc_pkg::PERIOD_W-1:0] period_reg;
    logic [dspdc_pkg::PERIOD_W-1:0] countdown_reg;
    logic [dspdc_pkg::PERIOD_W-1:0] countdown_next;
    logic [dspdc_pkg::PERIOD_W-1:0] count_dec;
    dspdc_pkg::thresholds_t         thresh_reg;
    dspdc_pkg::hold_level_t         first_level;
    dspdc_pkg::hold_level_t         second_level;
    logic                           accept;
    logic                           update;
    logic                           queue_full;

    assign cfg_ready = 1'b1;
    assign s_ready   = !queue_full;
    assign accept    = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg                <= dspdc_pkg::PERIOD_RESET;
            thresh_reg.full_threshold <= dspdc_pkg::FULL_RESET;
            thresh_reg.half_threshold <= dspdc_pkg::HALF_RESET;
            thresh_reg.min_threshold  <= dspdc_pkg::MIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (dspdc_pkg::cfg_reg_t'(cfg_index))
                dspdc_pkg::REG_SAMPLE_PERIOD: begin
                    period_reg <= cfg_data[dspdc_pkg::PERIOD_W-1:0];
                end
                dspdc_pkg::REG_FULL_THRESHOLD: begin
                    thresh_reg.full_threshold <= cfg_data;
                end
                dspdc_pkg::REG_HALF_THRESHOLD: begin
                    thresh_reg.half_threshold <= cfg_data;
                end
                dspdc_pkg::REG_MIN_THRESHOLD: begin
                    thresh_reg.min_threshold <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // sampling counter
    always_comb begin
        count_dec      = (countdown_reg != '0) ? countdown_reg - 8'd1 : countdown_reg;
        update         = (count_dec == '0);
        countdown_next = countdown_reg;
        if (accept) begin
            countdown_next = update ? period_reg : count_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            countdown_reg <= '0;
        end else begin
            countdown_reg <= countdown_next;
        end
    end

    dspdc_lane #(
        .INTEGRATOR_WIDTH(INTEGRATOR_WIDTH)
    ) u_lane_first (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (accept),
        .update    (update),
        .pressed   (s_data.first_pressed),
        .thresholds(thresh_reg),
        .level     (first_level)
    );

    dspdc_lane #(
        .INTEGRATOR_WIDTH(INTEGRATOR_WIDTH)
    ) u_lane_second (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (accept),
        .update    (update),
        .pressed   (s_data.second_pressed),
        .thresholds(thresh_reg),
        .level     (second_level)
    );

    dspdc_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (accept),
        .first_level (first_level),
        .second_level(second_level),
        .full        (queue_full),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // every accepted request leaves a result pending
    a_result_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("no result after accepted request");

    // input stalls only when results are waiting
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output queue");

    // counter reloads from the sample period on every accepted request that updates the lanes
    a_countdown_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && update) |=> (countdown_reg == $past(period_reg)))
        else $error("sampling counter did not reload");

endmodule

`default_nettype wire
